[hw/rtl/ael_pkg.sv]
// Shared constants and types for the AHDS envelope level unit.
// No dependencies.
package ael_pkg;

    localparam int TIME_BITS_DEF       = 24;
    localparam int LEVEL_FRAC_BITS_DEF = 15;
    localparam int CFG_INDEX_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_LEN    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_LEN      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_LEN     = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_HOLD    = 2'd1,
        PH_DECAY   = 2'd2,
        PH_SUSTAIN = 2'd3
    } phase_t;

endpackage

[hw/rtl/ael_classify.sv]
// First pipeline stage: phase decision and divider operand selection.
// Depends on ael_pkg.
module ael_classify #(
    parameter int TIME_BITS       = ael_pkg::TIME_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = ael_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TIME_BITS-1:0]       elapsed_ticks,
    input  logic [TIME_BITS-1:0]       attack_len,
    input  logic [TIME_BITS-1:0]       hold_len,
    input  logic [TIME_BITS-1:0]       decay_len,
    input  logic [LEVEL_FRAC_BITS:0]   sustain,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ael_pkg::phase_t            phase,
    output logic [TIME_BITS-1:0]       operand,
    output logic [LEVEL_FRAC_BITS:0]   scale,
    output logic [TIME_BITS-1:0]       divisor,
    output logic [LEVEL_FRAC_BITS:0]   fixed_level
);

    localparam logic [LEVEL_FRAC_BITS:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic                       valid_reg;
    ael_pkg::phase_t            phase_reg, phase_next;
    logic [TIME_BITS-1:0]       operand_reg, operand_next;
    logic [LEVEL_FRAC_BITS:0]   scale_reg, scale_next;
    logic [TIME_BITS-1:0]       divisor_reg, divisor_next;
    logic [LEVEL_FRAC_BITS:0]   fixed_reg, fixed_next;
    logic [TIME_BITS:0]         end_hold;
    logic [TIME_BITS+1:0]       end_decay;
    logic [TIME_BITS:0]         t_ext;
    logic [TIME_BITS:0]         u_full;

    always_comb begin
        end_hold     = {1'b0, attack_len} + {1'b0, hold_len};
        end_decay    = {1'b0, end_hold} + {2'b00, decay_len};
        t_ext        = {1'b0, elapsed_ticks};
        u_full       = t_ext - end_hold;
        phase_next   = ael_pkg::PH_SUSTAIN;
        operand_next = '0;
        scale_next   = '0;
        divisor_next = attack_len;
        fixed_next   = sustain;
        if (elapsed_ticks < attack_len) begin
            phase_next   = ael_pkg::PH_ATTACK;
            operand_next = elapsed_ticks;
            scale_next   = FULL;
        end else if (t_ext < end_hold) begin
            phase_next   = ael_pkg::PH_HOLD;
            fixed_next   = FULL;
        end else if ({1'b0, t_ext} < end_decay) begin
            phase_next   = ael_pkg::PH_DECAY;
            operand_next = u_full[TIME_BITS-1:0];
            scale_next   = FULL - sustain;
            divisor_next = decay_len;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg   <= phase_next;
            operand_reg <= operand_next;
            scale_reg   <= scale_next;
            divisor_reg <= divisor_next;
            fixed_reg   <= fixed_next;
        end
    end

    assign out_valid   = valid_reg;
    assign phase       = phase_reg;
    assign operand     = operand_reg;
    assign scale       = scale_reg;
    assign divisor     = divisor_reg;
    assign fixed_level = fixed_reg;

endmodule

[hw/rtl/ael_mul.sv]
// Second pipeline stage: operand times scale, split into the divider's
// starting remainder and the low numerator bits. Depends on ael_pkg.
module ael_mul #(
    parameter int TIME_BITS       = ael_pkg::TIME_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = ael_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ael_pkg::phase_t            in_phase,
    input  logic [TIME_BITS-1:0]       operand,
    input  logic [LEVEL_FRAC_BITS:0]   scale,
    input  logic [TIME_BITS-1:0]       in_divisor,
    input  logic [LEVEL_FRAC_BITS:0]   in_fixed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ael_pkg::phase_t            out_phase,
    output logic [TIME_BITS-1:0]       out_rem,
    output logic [LEVEL_FRAC_BITS-1:0] out_low,
    output logic [TIME_BITS-1:0]       out_divisor,
    output logic [LEVEL_FRAC_BITS:0]   out_fixed
);

    localparam int PROD_W = TIME_BITS + LEVEL_FRAC_BITS + 1;

    logic                       valid_reg;
    logic [PROD_W-1:0]          product_next;
    ael_pkg::phase_t            phase_reg;
    logic [TIME_BITS-1:0]       rem_reg;
    logic [LEVEL_FRAC_BITS-1:0] low_reg;
    logic [TIME_BITS-1:0]       divisor_reg;
    logic [LEVEL_FRAC_BITS:0]   fixed_reg;

    assign product_next = {{(LEVEL_FRAC_BITS+1){1'b0}}, operand}
                        * {{TIME_BITS{1'b0}}, scale};
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // quotient is below full scale, so the high part is already below the divisor
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg   <= in_phase;
            rem_reg     <= product_next[TIME_BITS+LEVEL_FRAC_BITS-1:LEVEL_FRAC_BITS];
            low_reg     <= product_next[LEVEL_FRAC_BITS-1:0];
            divisor_reg <= in_divisor;
            fixed_reg   <= in_fixed;
        end
    end

    assign out_valid   = valid_reg;
    assign out_phase   = phase_reg;
    assign out_rem     = rem_reg;
    assign out_low     = low_reg;
    assign out_divisor = divisor_reg;
    assign out_fixed   = fixed_reg;

endmodule

[hw/rtl/ael_div_step.sv]
// One restoring division stage: yields one quotient bit per register stage.
// Depends on ael_pkg.
module ael_div_step #(
    parameter int TIME_BITS       = ael_pkg::TIME_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = ael_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ael_pkg::phase_t            in_phase,
    input  logic [TIME_BITS-1:0]       in_rem,
    input  logic [LEVEL_FRAC_BITS-1:0] in_low,
    input  logic [LEVEL_FRAC_BITS-1:0] in_quo,
    input  logic [TIME_BITS-1:0]       in_divisor,
    input  logic [LEVEL_FRAC_BITS:0]   in_fixed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ael_pkg::phase_t            out_phase,
    output logic [TIME_BITS-1:0]       out_rem,
    output logic [LEVEL_FRAC_BITS-1:0] out_low,
    output logic [LEVEL_FRAC_BITS-1:0] out_quo,
    output logic [TIME_BITS-1:0]       out_divisor,
    output logic [LEVEL_FRAC_BITS:0]   out_fixed
);

    logic                       valid_reg;
    logic [TIME_BITS:0]         trial;
    logic [TIME_BITS:0]         diff;
    logic                       fits;
    logic [TIME_BITS-1:0]       rem_next;
    ael_pkg::phase_t            phase_reg;
    logic [TIME_BITS-1:0]       rem_reg;
    logic [LEVEL_FRAC_BITS-1:0] low_reg;
    logic [LEVEL_FRAC_BITS-1:0] quo_reg;
    logic [TIME_BITS-1:0]       divisor_reg;
    logic [LEVEL_FRAC_BITS:0]   fixed_reg;

    always_comb begin
        trial    = {in_rem, in_low[LEVEL_FRAC_BITS-1]};
        diff     = trial - {1'b0, in_divisor};
        fits     = trial >= {1'b0, in_divisor};
        rem_next = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg   <= in_phase;
            rem_reg     <= rem_next;
            low_reg     <= {in_low[LEVEL_FRAC_BITS-2:0], 1'b0};
            quo_reg     <= {in_quo[LEVEL_FRAC_BITS-2:0], fits};
            divisor_reg <= in_divisor;
            fixed_reg   <= in_fixed;
        end
    end

    assign out_valid   = valid_reg;
    assign out_phase   = phase_reg;
    assign out_rem     = rem_reg;
    assign out_low     = low_reg;
    assign out_quo     = quo_reg;
    assign out_divisor = divisor_reg;
    assign out_fixed   = fixed_reg;

endmodule

[hw/rtl/ahds_envelope_level_unit.sv]
// AHDS envelope level unit: top level with configuration registers,
// classify, multiply and divider pipeline. Depends on ael_pkg, ael_classify,
// ael_mul and ael_div_step.
//
// Takes one elapsed time per clock while s_ready is high and returns the
// envelope level and phase in order, one result per transfer. The stages are
// one for the phase decision, one for the multiplier, one per quotient bit of
// the restoring divider, and the output register. Every stage is decoupled by
// its own valid bit, so throughput is one item per cycle while the output is
// taken, and bubbles are squeezed out under back-pressure. Configuration
// writes take effect the next cycle and must only be issued with the pipeline
// empty.
module ahds_envelope_level_unit #(
    parameter int TIME_BITS       = ael_pkg::TIME_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = ael_pkg::LEVEL_FRAC_BITS_DEF,
    localparam int CFG_W = (TIME_BITS > LEVEL_FRAC_BITS + 1) ? TIME_BITS
                                                              : LEVEL_FRAC_BITS + 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ael_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [TIME_BITS-1:0]              s_elapsed_ticks,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [LEVEL_FRAC_BITS:0]          m_level,
    output logic [1:0]                        m_phase
);

    localparam int NSTEP = LEVEL_FRAC_BITS;
    localparam logic [LEVEL_FRAC_BITS:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic [TIME_BITS-1:0]       attack_len_reg;
    logic [TIME_BITS-1:0]       hold_len_reg;
    logic [TIME_BITS-1:0]       decay_len_reg;
    logic [LEVEL_FRAC_BITS:0]   sustain_level_reg;
    logic [LEVEL_FRAC_BITS:0]   sustain_sat;

    logic                       cls_valid, cls_ready;
    ael_pkg::phase_t            cls_phase;
    logic [TIME_BITS-1:0]       cls_operand;
    logic [LEVEL_FRAC_BITS:0]   cls_scale;
    logic [TIME_BITS-1:0]       cls_divisor;
    logic [LEVEL_FRAC_BITS:0]   cls_fixed;

    logic                       st_valid   [0:NSTEP];
    logic                       st_ready   [0:NSTEP];
    ael_pkg::phase_t            st_phase   [0:NSTEP];
    logic [TIME_BITS-1:0]       st_rem     [0:NSTEP];
    logic [LEVEL_FRAC_BITS-1:0] st_low     [0:NSTEP];
    logic [LEVEL_FRAC_BITS-1:0] st_quo     [0:NSTEP];
    logic [TIME_BITS-1:0]       st_divisor [0:NSTEP];
    logic [LEVEL_FRAC_BITS:0]   st_fixed   [0:NSTEP];

    logic                       m_valid_reg;
    logic [LEVEL_FRAC_BITS:0]   level_reg, level_next;
    ael_pkg::phase_t            phase_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg    <= '0;
            hold_len_reg      <= '0;
            decay_len_reg     <= '0;
            sustain_level_reg <= FULL;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ael_pkg::REG_ATTACK_LEN:    attack_len_reg    <= cfg_wdata[TIME_BITS-1:0];
                ael_pkg::REG_HOLD_LEN:      hold_len_reg      <= cfg_wdata[TIME_BITS-1:0];
                ael_pkg::REG_DECAY_LEN:     decay_len_reg     <= cfg_wdata[TIME_BITS-1:0];
                ael_pkg::REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wdata[LEVEL_FRAC_BITS:0];
                default: ;
            endcase
        end
    end

    assign sustain_sat = (sustain_level_reg > FULL) ? FULL : sustain_level_reg;

    ael_classify #(
        .TIME_BITS       (TIME_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .elapsed_ticks (s_elapsed_ticks),
        .attack_len    (attack_len_reg),
        .hold_len      (hold_len_reg),
        .decay_len     (decay_len_reg),
        .sustain       (sustain_sat),
        .out_valid     (cls_valid),
        .out_ready     (cls_ready),
        .phase         (cls_phase),
        .operand       (cls_operand),
        .scale         (cls_scale),
        .divisor       (cls_divisor),
        .fixed_level   (cls_fixed)
    );

    ael_mul #(
        .TIME_BITS       (TIME_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cls_valid),
        .in_ready    (cls_ready),
        .in_phase    (cls_phase),
        .operand     (cls_operand),
        .scale       (cls_scale),
        .in_divisor  (cls_divisor),
        .in_fixed    (cls_fixed),
        .out_valid   (st_valid[0]),
        .out_ready   (st_ready[0]),
        .out_phase   (st_phase[0]),
        .out_rem     (st_rem[0]),
        .out_low     (st_low[0]),
        .out_divisor (st_divisor[0]),
        .out_fixed   (st_fixed[0])
    );

    assign st_quo[0] = '0;

    for (genvar i = 0; i < NSTEP; i++) begin : g_div
        ael_div_step #(
            .TIME_BITS       (TIME_BITS),
            .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
        ) u_step (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid    (st_valid[i]),
            .in_ready    (st_ready[i]),
            .in_phase    (st_phase[i]),
            .in_rem      (st_rem[i]),
            .in_low      (st_low[i]),
            .in_quo      (st_quo[i]),
            .in_divisor  (st_divisor[i]),
            .in_fixed    (st_fixed[i]),
            .out_valid   (st_valid[i+1]),
            .out_ready   (st_ready[i+1]),
            .out_phase   (st_phase[i+1]),
            .out_rem     (st_rem[i+1]),
            .out_low     (st_low[i+1]),
            .out_quo     (st_quo[i+1]),
            .out_divisor (st_divisor[i+1]),
            .out_fixed   (st_fixed[i+1])
        );
    end

    // output register
    always_comb begin
        case (st_phase[NSTEP])
            ael_pkg::PH_ATTACK: level_next = {1'b0, st_quo[NSTEP]};
            ael_pkg::PH_DECAY:  level_next = FULL - {1'b0, st_quo[NSTEP]};
            default:            level_next = st_fixed[NSTEP];
        endcase
    end

    assign st_ready[NSTEP] = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready[NSTEP]) begin
            m_valid_reg <= st_valid[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready[NSTEP] && st_valid[NSTEP]) begin
            level_reg <= level_next;
            phase_reg <= st_phase[NSTEP];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = level_reg;
    assign m_phase = phase_reg;

endmodule

[hw/rtl/ael_checker.sv]
// Port-level checks for the AHDS envelope level unit, bound to the top level.
// Depends on ael_pkg and ahds_envelope_level_unit.
module ael_checker #(
    parameter int LEVEL_FRAC_BITS = ael_pkg::LEVEL_FRAC_BITS_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [LEVEL_FRAC_BITS:0] m_level,
    input logic [1:0]               m_phase
);

    localparam logic [LEVEL_FRAC_BITS:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    // stalled transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_phase))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_level <= FULL)
        else $error("level above full scale");

    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == ael_pkg::PH_HOLD |-> m_level == FULL)
        else $error("hold phase not at full scale");

    a_attack_below: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == ael_pkg::PH_ATTACK |-> m_level < FULL)
        else $error("attack level reached full scale");

endmodule

bind ahds_envelope_level_unit ael_checker #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_ael_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_level (m_level),
    .m_phase (m_phase)
);

[bench/ahds_envelope_level_checker.sv]
// Checker for the AHDS envelope level unit: tracks register writes, predicts the
// level and phase of each input transfer and compares result transfers in order.
// Depends on ael_pkg.
module ahds_envelope_level_checker
    import ael_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [TIME_BITS_DEF-1:0]       cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [TIME_BITS_DEF-1:0]       s_elapsed_ticks,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [LEVEL_FRAC_BITS_DEF:0]   m_level,
    input  logic [1:0]                     m_phase,
    output int                             failures,
    output int                             pending
);

    localparam int TB = TIME_BITS_DEF;
    localparam int LB = LEVEL_FRAC_BITS_DEF;
    localparam logic [63:0] FULL_SCALE = 64'd1 << LB;

    typedef struct packed {
        logic [LB:0] level;
        phase_t      phase;
    } envelope_t;

    logic [TB-1:0] attack_q;
    logic [TB-1:0] hold_q;
    logic [TB-1:0] decay_q;
    logic [LB:0]   sustain_q;
    envelope_t     envelope_q[$];
    int            fail_count = 0;

    function automatic envelope_t envelope_at(input logic [TB-1:0] t);
        logic [63:0] tt;
        logic [63:0] sus;
        logic [63:0] end_hold;
        logic [63:0] end_decay;
        logic [63:0] lvl;
        envelope_t   r;
        tt        = 64'(t);
        sus       = (64'(sustain_q) > FULL_SCALE) ? FULL_SCALE : 64'(sustain_q);
        end_hold  = 64'(attack_q) + 64'(hold_q);
        end_decay = end_hold + 64'(decay_q);
        if (tt < 64'(attack_q)) begin
            lvl     = (tt * FULL_SCALE) / 64'(attack_q);
            r.phase = PH_ATTACK;
        end else if (tt < end_hold) begin
            lvl     = FULL_SCALE;
            r.phase = PH_HOLD;
        end else if (tt < end_decay) begin
            lvl     = FULL_SCALE - ((FULL_SCALE - sus) * (tt - end_hold)) / 64'(decay_q);
            r.phase = PH_DECAY;
        end else begin
            lvl     = sus;
            r.phase = PH_SUSTAIN;
        end
        r.level = lvl[LB:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        envelope_t want;
        if (!aresetn) begin
            attack_q  = '0;
            hold_q    = '0;
            decay_q   = '0;
            sustain_q = (LB+1)'(FULL_SCALE);
            envelope_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ATTACK_LEN:    attack_q  = cfg_wdata[TB-1:0];
                    REG_HOLD_LEN:      hold_q    = cfg_wdata[TB-1:0];
                    REG_DECAY_LEN:     decay_q   = cfg_wdata[TB-1:0];
                    REG_SUSTAIN_LEVEL: sustain_q = cfg_wdata[LB:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                envelope_q.push_back(envelope_at(s_elapsed_ticks));
            end
            if (m_valid && m_ready) begin
                if (envelope_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, level %0d phase %0d",
                             $time, m_level, m_phase);
                    fail_count++;
                end else begin
                    want = envelope_q.pop_front();
                    if (m_level !== want.level) begin
                        $display("%0t: level mismatch: expected %0d, actual %0d",
                                 $time, want.level, m_level);
                        fail_count++;
                    end
                    if (m_phase !== want.phase) begin
                        $display("%0t: phase mismatch: expected %0d, actual %0d",
                                 $time, want.phase, m_phase);
                        fail_count++;
                    end
                end
            end
        end
        failures <= fail_count;
        pending  <= envelope_q.size();
    end

endmodule

[bench/ahds_envelope_level_unit_test.sv]
// Testbench top for the AHDS envelope level unit: reset, register settings,
// directed and random elapsed times with random idling, and the verdict.
// Depends on ael_pkg, ahds_envelope_level_unit and ahds_envelope_level_checker.
module ahds_envelope_level_unit_test;
    import ael_pkg::*;

    localparam int          TB          = TIME_BITS_DEF;
    localparam int          LB          = LEVEL_FRAC_BITS_DEF;
    localparam logic [63:0] MAX_TICKS   = (64'd1 << TB) - 1;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          TAIL_CYCLES = LB + 10;
    localparam int          RAND_PHASES = 12;
    localparam int          PHASE_ITEMS = 90;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ATTACK_LEN;
    logic [TB-1:0]             cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [TB-1:0]             s_elapsed_ticks = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [LB:0]               m_level;
    logic [1:0]                m_phase;
    int                        failures;
    int                        pending;

    logic [63:0] atk_len = 0;
    logic [63:0] hld_len = 0;
    logic [63:0] dcy_len = 0;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          stall_left = 0;
    int          cycle_count = 0;

    ahds_envelope_level_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_elapsed_ticks (s_elapsed_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_phase         (m_phase)
    );

    ahds_envelope_level_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_elapsed_ticks (s_elapsed_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_phase         (m_phase),
        .failures        (failures),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ahds_envelope_level_unit: FAILED **");
            $finish;
        end
    end

    // result side back-pressure, in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 2);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic apply_config(input logic [TB-1:0] a, input logic [TB-1:0] h,
                                input logic [TB-1:0] d, input logic [LB:0] s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ATTACK_LEN;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_index <= REG_HOLD_LEN;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_index <= REG_DECAY_LEN;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_index <= REG_SUSTAIN_LEVEL;
        cfg_wdata <= {(TB-LB-1)'($urandom), s};
        @(posedge aclk);
        cfg_we  <= 1'b0;
        atk_len = 64'(a);
        hld_len = 64'(h);
        dcy_len = 64'(d);
    endtask

    task automatic send_ticks(input logic [TB-1:0] t);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_elapsed_ticks <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    function automatic logic [TB-1:0] pick_len();
        case ($urandom_range(0, 11))
            0, 1:    return '0;
            2, 3, 4: return TB'($urandom_range(1, 64));
            5, 6:    return TB'($urandom_range(1, 5000));
            7:       return TB'(MAX_TICKS - $urandom_range(0, 3));
            default: return TB'($urandom);
        endcase
    endfunction

    function automatic logic [LB:0] pick_sustain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return (LB+1)'(1 << LB);
            2:       return (LB+1)'($urandom_range((1 << LB) + 1, (1 << (LB + 1)) - 1));
            3:       return (LB+1)'($urandom);
            default: return (LB+1)'($urandom_range(0, 1 << LB));
        endcase
    endfunction

    // mostly times spread over the programmed envelope, some near the phase
    // boundaries, a few anywhere
    function automatic logic [TB-1:0] pick_ticks();
        logic [63:0] end_hold;
        logic [63:0] end_decay;
        logic [63:0] span;
        logic [63:0] bound_pt;
        end_hold  = atk_len + hld_len;
        end_decay = end_hold + dcy_len;
        case ($urandom_range(0, 7))
            0: return TB'($urandom);
            1, 2: begin
                case ($urandom_range(0, 2))
                    0:       bound_pt = atk_len;
                    1:       bound_pt = end_hold;
                    default: bound_pt = end_decay;
                endcase
                bound_pt = bound_pt + 64'($urandom_range(0, 4));
                bound_pt = (bound_pt < 2) ? 64'd0 : bound_pt - 2;
                if (bound_pt > MAX_TICKS) bound_pt = MAX_TICKS;
                return bound_pt[TB-1:0];
            end
            default: begin
                span = end_decay + end_decay / 8 + 4;
                if (span > MAX_TICKS) span = MAX_TICKS;
                return TB'($urandom_range(0, span[31:0]));
            end
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: every phase empty, sustain at full scale
        send_ticks('0);
        send_ticks(TB'(MAX_TICKS));
        drain_results();

        apply_config(TB'(100), TB'(50), TB'(200), (LB+1)'(16384));
        send_ticks(TB'(0));
        send_ticks(TB'(1));
        send_ticks(TB'(99));
        send_ticks(TB'(100));
        send_ticks(TB'(149));
        send_ticks(TB'(150));
        send_ticks(TB'(151));
        send_ticks(TB'(349));
        send_ticks(TB'(350));
        send_ticks(TB'(MAX_TICKS));
        drain_results();

        // longest phases, sums beyond the time width
        apply_config(TB'(MAX_TICKS), TB'(MAX_TICKS), TB'(MAX_TICKS), '0);
        send_ticks(TB'(0));
        send_ticks(TB'(1));
        send_ticks(TB'(MAX_TICKS - 1));
        send_ticks(TB'(MAX_TICKS));
        drain_results();

        // sustain above full scale saturates, decay stays flat
        apply_config('0, '0, TB'(10), (LB+1)'((1 << (LB + 1)) - 1));
        send_ticks(TB'(0));
        send_ticks(TB'(5));
        send_ticks(TB'(9));
        send_ticks(TB'(10));
        drain_results();

        apply_config(TB'(1), '0, TB'(1), (LB+1)'(1 << LB));
        send_ticks(TB'(0));
        send_ticks(TB'(1));
        send_ticks(TB'(2));
        drain_results();

        apply_config('0, TB'(3), '0, '0);
        send_ticks(TB'(0));
        send_ticks(TB'(2));
        send_ticks(TB'(3));
        drain_results();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < RAND_PHASES - 2) begin
                idle_pct  = 15 * $urandom_range(0, 2);
                stall_pct = 15 * $urandom_range(0, 2);
            end else begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            apply_config(pick_len(), pick_len(), pick_len(), pick_sustain());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_ticks(pick_ticks());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("** ahds_envelope_level_unit: PASSED **");
        end else begin
            $display("** ahds_envelope_level_unit: FAILED **");
        end
        $finish;
    end

endmodule
